### sv/bsce_pkg.sv
// Shared constants, codes, command/status structs and reply tables for the
// serial boot command engine. No dependencies.
package bsce_pkg;

  localparam int STORE_BYTES = 65536;
  localparam int STORE_AW    = $clog2(STORE_BYTES);
  localparam int BUF_BYTES   = 256;
  localparam int BUF_AW      = $clog2(BUF_BYTES);
  localparam int PAGE_BYTES  = 1024;

  localparam logic [7:0] ACK_BYTE  = 8'h79;
  localparam logic [7:0] NACK_BYTE = 8'h1F;
  localparam logic [7:0] SYNC_BYTE = 8'h7F;
  localparam logic [7:0] ALL_ONES  = 8'hFF;

  // command selectors: second byte minus first byte
  localparam logic [7:0] DIFF_GET   = 8'hFF;
  localparam logic [7:0] DIFF_VER   = 8'hFD;
  localparam logic [7:0] DIFF_ID    = 8'hFB;
  localparam logic [7:0] DIFF_RM    = 8'hDD;
  localparam logic [7:0] DIFF_GO    = 8'hBD;
  localparam logic [7:0] DIFF_WM    = 8'h9D;
  localparam logic [7:0] DIFF_ER    = 8'h79;
  localparam logic [7:0] DIFF_MAGIC = 8'h00;

  localparam logic REG_APP_BASE = 1'b0;
  localparam logic REG_APP_END  = 1'b1;

  // reply kinds
  localparam logic [2:0] K_ACK  = 3'd0;
  localparam logic [2:0] K_NACK = 3'd1;
  localparam logic [2:0] K_GO   = 3'd2;
  localparam logic [2:0] K_GET  = 3'd3;
  localparam logic [2:0] K_VER  = 3'd4;
  localparam logic [2:0] K_ID   = 3'd5;
  localparam logic [2:0] K_RD   = 3'd6;

  typedef struct packed {
    logic       latch_in;
    logic       set_first;
    logic       addr_start;
    logic       addr_take;
    logic       idx_clr;
    logic       idx_inc;
    logic       cnt_load;
    logic       chk_load;
    logic       chk_xor;
    logic       buf_wr;
    logic       send_load;
    logic       pull_rd;
    logic       rep_start;
    logic [2:0] rep_kind;
    logic       out_load;
    logic       sweep_clr;
    logic       sweep_inc;
    logic       clear_wr;
    logic       erase_wr;
    logic       erase_set;
    logic       wr_init;
    logic       wr_rd;
    logic       wr_wr;
    logic       wr_step;
  } bsce_cmd_t;

  typedef struct packed {
    logic       func;
    logic [7:0] rx;
    logic [7:0] diff;
    logic       chk_x_zero;
    logic       take_done;
    logic       magic_done;
    logic       wm_last;
    logic       er_done;
    logic       rem_nz;
    logic       erase_done;
    logic       span_ok;
    logic       sweep_in;
    logic       sweep_last;
    logic       win_ok;
    logic       sel;
    logic       wr_last;
    logic       rep_last;
    logic       out_free;
  } bsce_sts_t;

  function automatic logic [3:0] reply_len(input logic [2:0] kind);
    unique case (kind)
      K_GET:        reply_len = 4'd11;
      K_VER, K_ID:  reply_len = 4'd5;
      default:      reply_len = 4'd1;
    endcase
  endfunction

  function automatic logic [7:0] get_tab(input logic [3:0] i);
    unique case (i)
      4'd0:    get_tab = 8'h07;
      4'd1:    get_tab = 8'h10;
      4'd2:    get_tab = 8'h00;
      4'd3:    get_tab = 8'h01;
      4'd4:    get_tab = 8'h02;
      4'd5:    get_tab = 8'h11;
      4'd6:    get_tab = 8'h21;
      4'd7:    get_tab = 8'h31;
      4'd8:    get_tab = 8'h43;
      default: get_tab = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] ver_tab(input logic [3:0] i);
    unique case (i)
      4'd0:    ver_tab = 8'h10;
      default: ver_tab = 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] id_tab(input logic [3:0] i);
    unique case (i)
      4'd0:    id_tab = 8'h01;
      4'd1:    id_tab = 8'h04;
      default: id_tab = 8'h10;
    endcase
  endfunction

  // byte idx of a reply; framed replies carry an ACK at each end
  function automatic logic [7:0] reply_byte(input logic [2:0] kind, input logic [3:0] idx,
                                            input logic [7:0] rd);
    logic framed_end;
    framed_end = (idx == 4'd0) || (idx == reply_len(kind) - 4'd1);
    unique case (kind)
      K_NACK:  reply_byte = NACK_BYTE;
      K_RD:    reply_byte = rd;
      K_GET:   reply_byte = framed_end ? ACK_BYTE : get_tab(idx - 4'd1);
      K_VER:   reply_byte = framed_end ? ACK_BYTE : ver_tab(idx - 4'd1);
      K_ID:    reply_byte = framed_end ? ACK_BYTE : id_tab(idx - 4'd1);
      default: reply_byte = ACK_BYTE;
    endcase
  endfunction

endpackage

### sv/bsce_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module bsce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

### sv/bsce_ctrl.sv
// Controller: protocol phase and sequencing of the datapath.
// Depends on bsce_pkg.
module bsce_ctrl import bsce_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  bsce_sts_t sts,
  output bsce_cmd_t cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_EXEC  = 4'd2;
  localparam logic [3:0] S_EMIT  = 4'd3;
  localparam logic [3:0] S_PULL  = 4'd4;
  localparam logic [3:0] S_WCHK  = 4'd5;
  localparam logic [3:0] S_WWR   = 4'd6;
  localparam logic [3:0] S_ERASE = 4'd7;

  localparam logic [3:0] PH_WAIT      = 4'd0;
  localparam logic [3:0] PH_CMD2      = 4'd1;
  localparam logic [3:0] PH_MAGIC     = 4'd2;
  localparam logic [3:0] PH_RM_ADDR   = 4'd3;
  localparam logic [3:0] PH_RM_LEN    = 4'd4;
  localparam logic [3:0] PH_RM_CK     = 4'd5;
  localparam logic [3:0] PH_GO_ADDR   = 4'd6;
  localparam logic [3:0] PH_WM_ADDR   = 4'd7;
  localparam logic [3:0] PH_WM_LEN    = 4'd8;
  localparam logic [3:0] PH_WM_DATA   = 4'd9;
  localparam logic [3:0] PH_WM_CK     = 4'd10;
  localparam logic [3:0] PH_ER_FIRST  = 4'd11;
  localparam logic [3:0] PH_ER_GLOBAL = 4'd12;
  localparam logic [3:0] PH_ER_LIST   = 4'd13;

  logic [3:0] st_r, st_nxt;
  logic [3:0] ph_r, ph_nxt;

  assign in_tready = (st_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR;
      ph_r <= PH_WAIT;
    end else begin
      st_r <= st_nxt;
      ph_r <= ph_nxt;
    end
  end

  always_comb begin
    cmd    = '0;
    st_nxt = st_r;
    ph_nxt = ph_r;
    unique case (st_r)
      S_CLR: begin
        cmd.clear_wr = 1'b1;
        if (sts.sweep_last) begin
          st_nxt = S_IDLE;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          st_nxt       = S_EXEC;
        end
      end
      S_EXEC: begin
        st_nxt = S_IDLE;
        if (sts.func) begin
          if (sts.rem_nz) begin
            cmd.pull_rd = 1'b1;
            st_nxt      = S_PULL;
          end
        end else begin
          unique case (ph_r)
            PH_WAIT: begin
              if (sts.rx == SYNC_BYTE) begin
                cmd.rep_start = 1'b1;
                cmd.rep_kind  = K_ACK;
                st_nxt        = S_EMIT;
              end else begin
                cmd.set_first = 1'b1;
                ph_nxt        = PH_CMD2;
              end
            end
            PH_CMD2: begin
              ph_nxt        = PH_WAIT;
              cmd.rep_start = 1'b1;
              st_nxt        = S_EMIT;
              unique case (sts.diff)
                DIFF_GET: cmd.rep_kind = K_GET;
                DIFF_VER: cmd.rep_kind = K_VER;
                DIFF_ID:  cmd.rep_kind = K_ID;
                DIFF_RM: begin
                  cmd.rep_kind   = K_ACK;
                  cmd.addr_start = 1'b1;
                  ph_nxt         = PH_RM_ADDR;
                end
                DIFF_GO: begin
                  cmd.rep_kind   = K_ACK;
                  cmd.addr_start = 1'b1;
                  ph_nxt         = PH_GO_ADDR;
                end
                DIFF_WM: begin
                  cmd.rep_kind   = K_ACK;
                  cmd.addr_start = 1'b1;
                  ph_nxt         = PH_WM_ADDR;
                end
                DIFF_ER: begin
                  cmd.rep_kind = K_ACK;
                  ph_nxt       = PH_ER_FIRST;
                end
                DIFF_MAGIC: begin
                  cmd.rep_start = 1'b0;
                  cmd.idx_clr   = 1'b1;
                  ph_nxt        = PH_MAGIC;
                  st_nxt        = S_IDLE;
                end
                default: cmd.rep_kind = K_NACK;
              endcase
            end
            PH_MAGIC: begin
              cmd.idx_inc = 1'b1;
              if (sts.magic_done) begin
                ph_nxt = PH_WAIT;
              end
            end
            PH_RM_ADDR, PH_WM_ADDR: begin
              cmd.addr_take = 1'b1;
              if (sts.take_done) begin
                cmd.rep_start = 1'b1;
                st_nxt        = S_EMIT;
                if (!sts.chk_x_zero) begin
                  cmd.rep_kind = K_NACK;
                  ph_nxt       = PH_WAIT;
                end else begin
                  cmd.rep_kind = K_ACK;
                  ph_nxt       = (ph_r == PH_RM_ADDR) ? PH_RM_LEN : PH_WM_LEN;
                end
              end
            end
            PH_RM_LEN: begin
              cmd.cnt_load = 1'b1;
              ph_nxt       = PH_RM_CK;
            end
            PH_RM_CK: begin
              cmd.send_load = 1'b1;
              cmd.rep_start = 1'b1;
              cmd.rep_kind  = K_ACK;
              st_nxt        = S_EMIT;
              ph_nxt        = PH_WAIT;
            end
            PH_GO_ADDR: begin
              cmd.addr_take = 1'b1;
              if (sts.take_done) begin
                cmd.rep_start = 1'b1;
                cmd.rep_kind  = K_GO;
                st_nxt        = S_EMIT;
                ph_nxt        = PH_WAIT;
              end
            end
            PH_WM_LEN: begin
              cmd.cnt_load = 1'b1;
              cmd.chk_load = 1'b1;
              cmd.idx_clr  = 1'b1;
              ph_nxt       = PH_WM_DATA;
            end
            PH_WM_DATA: begin
              cmd.buf_wr  = 1'b1;
              cmd.chk_xor = 1'b1;
              cmd.idx_inc = 1'b1;
              if (sts.wm_last) begin
                ph_nxt = PH_WM_CK;
              end
            end
            PH_WM_CK: begin
              ph_nxt = PH_WAIT;
              if (!sts.chk_x_zero) begin
                cmd.rep_start = 1'b1;
                cmd.rep_kind  = K_NACK;
                st_nxt        = S_EMIT;
              end else begin
                cmd.wr_init = 1'b1;
                st_nxt      = S_WCHK;
              end
            end
            PH_ER_FIRST: begin
              if (sts.rx == ALL_ONES) begin
                ph_nxt = PH_ER_GLOBAL;
              end else begin
                cmd.cnt_load = 1'b1;
                cmd.chk_load = 1'b1;
                cmd.idx_clr  = 1'b1;
                ph_nxt       = PH_ER_LIST;
              end
            end
            PH_ER_GLOBAL, PH_ER_LIST: begin
              if (ph_r == PH_ER_LIST) begin
                cmd.chk_xor = 1'b1;
                cmd.idx_inc = 1'b1;
              end
              if (ph_r == PH_ER_GLOBAL || sts.er_done) begin
                ph_nxt = PH_WAIT;
                if (ph_r == PH_ER_LIST && !sts.chk_x_zero) begin
                  cmd.rep_start = 1'b1;
                  cmd.rep_kind  = K_NACK;
                  st_nxt        = S_EMIT;
                end else if (sts.erase_done || !sts.span_ok) begin
                  cmd.erase_set = 1'b1;
                  cmd.rep_start = 1'b1;
                  cmd.rep_kind  = K_ACK;
                  st_nxt        = S_EMIT;
                end else begin
                  cmd.sweep_clr = 1'b1;
                  st_nxt        = S_ERASE;
                end
              end
            end
            default: ph_nxt = PH_WAIT;
          endcase
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          if (sts.rep_last) begin
            st_nxt = S_IDLE;
          end
        end
      end
      S_PULL: begin
        cmd.rep_start = 1'b1;
        cmd.rep_kind  = K_RD;
        st_nxt        = S_EMIT;
      end
      S_WCHK: begin
        if (sts.win_ok) begin
          cmd.wr_rd = 1'b1;
          st_nxt    = S_WWR;
        end else begin
          cmd.rep_start = 1'b1;
          cmd.rep_kind  = K_ACK;
          st_nxt        = S_EMIT;
        end
      end
      S_WWR: begin
        cmd.wr_wr   = 1'b1;
        cmd.wr_step = 1'b1;
        if (!sts.sel) begin
          cmd.wr_rd = 1'b1;
        end else if (sts.wr_last) begin
          cmd.rep_start = 1'b1;
          cmd.rep_kind  = K_ACK;
          st_nxt        = S_EMIT;
        end else begin
          st_nxt = S_WCHK;
        end
      end
      S_ERASE: begin
        if (sts.sweep_in) begin
          cmd.erase_wr = 1'b1;
        end
        if (!sts.sweep_in || sts.sweep_last) begin
          cmd.erase_set = 1'b1;
          cmd.rep_start = 1'b1;
          cmd.rep_kind  = K_ACK;
          st_nxt        = S_EMIT;
        end else begin
          cmd.sweep_inc = 1'b1;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

endmodule

### sv/bsce_dp.sv
// Datapath: address/check/count registers, payload buffer, image store,
// output word register. Depends on bsce_pkg and bsce_ram.
module bsce_dp import bsce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,
  output logic        out_tlast,
  output logic        out_tuser,
  input  bsce_cmd_t   cmd,
  output bsce_sts_t   sts
);

  logic [31:0] base_r, end_r;
  logic        func_r;
  logic [7:0]  rx_r;
  logic [7:0]  first_r;
  logic [31:0] addr_r;
  logic [7:0]  chk_r;
  logic [7:0]  cnt_r;
  logic [8:0]  idx_r;
  logic [31:0] send_addr_r;
  logic [8:0]  send_rem_r;
  logic        erase_done_r;
  logic [STORE_AW-1:0] ctr_r;
  logic [7:0]  hi_r, hi_nxt;
  logic        sel_r, sel_nxt;
  logic [2:0]  kind_r;
  logic [3:0]  ridx_r;
  logic        rd_zero_r;
  logic        out_valid_r;
  logic [7:0]  out_data_r;
  logic        out_last_r, out_user_r;

  logic [31:0] span, wa, woff, roff;
  logic        wok, rok;
  logic [7:0]  store_q, buf_q, rd_byte;

  logic                store_we, store_re;
  logic [STORE_AW-1:0] store_addr;
  logic [7:0]          store_wdata;
  logic                buf_we;
  logic [BUF_AW-1:0]   buf_addr;
  logic [7:0]          buf_wdata;

  assign span = end_r - base_r;
  assign wa   = addr_r + {31'd0, sel_r};
  assign woff = wa - base_r;
  assign wok  = (wa >= base_r) && (woff < 32'(STORE_BYTES));
  assign roff = send_addr_r - base_r;
  assign rok  = (send_addr_r >= base_r) && (roff < 32'(STORE_BYTES));
  assign rd_byte = rd_zero_r ? 8'd0 : store_q;

  always_comb begin
    hi_nxt  = hi_r;
    sel_nxt = sel_r;
    if (cmd.wr_init) begin
      hi_nxt  = '0;
      sel_nxt = 1'b0;
    end else if (cmd.wr_step) begin
      sel_nxt = ~sel_r;
      if (sel_r) begin
        hi_nxt = hi_r + 8'd1;
      end
    end
  end

  // store port: sweeps use the counter, otherwise write or read offset
  assign store_we    = cmd.clear_wr | cmd.erase_wr | (cmd.wr_wr & wok);
  assign store_re    = cmd.pull_rd;
  assign store_wdata = cmd.wr_wr ? buf_q : ALL_ONES;
  always_comb begin
    priority if (cmd.pull_rd) begin
      store_addr = roff[STORE_AW-1:0];
    end else if (cmd.wr_wr) begin
      store_addr = woff[STORE_AW-1:0];
    end else begin
      store_addr = ctr_r;
    end
  end

  assign buf_we    = cmd.clear_wr | cmd.buf_wr;
  assign buf_wdata = cmd.clear_wr ? 8'd0 : rx_r;
  always_comb begin
    priority if (cmd.clear_wr) begin
      buf_addr = ctr_r[BUF_AW-1:0];
    end else if (cmd.buf_wr) begin
      buf_addr = idx_r[BUF_AW-1:0];
    end else begin
      buf_addr = {hi_nxt[BUF_AW-2:0], sel_nxt};
    end
  end

  bsce_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (store_we),
    .re    (store_re),
    .addr  (store_addr),
    .wdata (store_wdata),
    .rdata (store_q)
  );

  bsce_ram #(.WIDTH(8), .DEPTH(BUF_BYTES)) u_buf (
    .clk   (clk),
    .we    (buf_we),
    .re    (cmd.wr_rd),
    .addr  (buf_addr),
    .wdata (buf_wdata),
    .rdata (buf_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r       <= 32'd134221824;
      end_r        <= 32'd134283264;
      first_r      <= '0;
      addr_r       <= '0;
      chk_r        <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      send_addr_r  <= '0;
      send_rem_r   <= '0;
      erase_done_r <= 1'b0;
      ctr_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_APP_BASE) begin
          base_r <= cfg_wdata;
        end else begin
          end_r <= cfg_wdata;
        end
      end
      if (cmd.set_first) begin
        first_r <= rx_r;
      end
      if (cmd.addr_start) begin
        addr_r <= '0;
      end else if (cmd.addr_take && idx_r < 9'd4) begin
        addr_r <= {addr_r[23:0], rx_r};
      end else if (cmd.wr_step && sel_r) begin
        addr_r <= addr_r + 32'd2;
      end
      if (cmd.addr_start) begin
        chk_r <= '0;
      end else if (cmd.chk_load) begin
        chk_r <= rx_r;
      end else if (cmd.chk_xor || cmd.addr_take) begin
        chk_r <= chk_r ^ rx_r;
      end
      if (cmd.cnt_load) begin
        cnt_r <= rx_r;
      end
      if (cmd.addr_start || cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc || cmd.addr_take) begin
        idx_r <= idx_r + 9'd1;
      end
      if (cmd.send_load) begin
        send_addr_r <= addr_r;
        send_rem_r  <= {1'b0, cnt_r} + 9'd1;
      end else if (cmd.pull_rd) begin
        send_addr_r <= send_addr_r + 32'd1;
        send_rem_r  <= send_rem_r - 9'd1;
      end
      if (cmd.erase_set) begin
        erase_done_r <= 1'b1;
      end
      if (cmd.sweep_clr) begin
        ctr_r <= '0;
      end else if (cmd.sweep_inc) begin
        ctr_r <= ctr_r + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      func_r <= in_tuser;
      rx_r   <= in_tdata;
    end
    hi_r  <= hi_nxt;
    sel_r <= sel_nxt;
    if (cmd.pull_rd) begin
      rd_zero_r <= !rok;
    end
    if (cmd.rep_start) begin
      kind_r <= cmd.rep_kind;
      ridx_r <= '0;
    end else if (cmd.out_load) begin
      ridx_r <= ridx_r + 4'd1;
    end
    if (cmd.out_load) begin
      out_data_r <= reply_byte(kind_r, ridx_r, rd_byte);
      out_last_r <= sts.rep_last;
      out_user_r <= (kind_r == K_GO);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_user_r;

  always_comb begin
    sts            = '0;
    sts.func       = func_r;
    sts.rx         = rx_r;
    sts.diff       = rx_r - first_r;
    sts.chk_x_zero = ((chk_r ^ rx_r) == 8'd0);
    sts.take_done  = (idx_r + 9'd1 >= 9'd5);
    sts.magic_done = (idx_r + 9'd1 >= 9'd12);
    sts.wm_last    = (idx_r >= {1'b0, cnt_r});
    sts.er_done    = ({1'b0, idx_r} + 10'd1 >= {2'b0, cnt_r} + 10'd2);
    sts.rem_nz     = (send_rem_r != 9'd0);
    sts.erase_done = erase_done_r;
    sts.span_ok    = (end_r > base_r);
    sts.sweep_in   = ((32'(ctr_r) & ~32'(PAGE_BYTES - 1)) < span);
    sts.sweep_last = (ctr_r == STORE_AW'(STORE_BYTES - 1));
    sts.win_ok     = (addr_r >= base_r) && (addr_r < end_r);
    sts.sel        = sel_r;
    sts.wr_last    = sel_r && (hi_r[BUF_AW-2:0] == cnt_r[BUF_AW-1:1]);
    sts.rep_last   = (ridx_r == reply_len(kind_r) - 4'd1);
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

### sv/serial_boot_command_engine.sv
// Serial boot loader command engine: one host byte or transmit pull per
// input word. Depends on bsce_pkg, bsce_ctrl, bsce_dp.
//
// After reset the block runs a clearing pass (image store set to 0xFF,
// payload buffer zeroed) with in_tready low; configuration writes are
// taken meanwhile. Each input word is latched and decoded, then any reply
// is loaded byte by byte (up to 11 bytes for the get reply) while the output
// register drains. A successful write command checks each half-word address
// against the window and writes both bytes from the payload buffer to the
// store; the first erase sweeps the store one byte per cycle, up to the whole
// store. Read data is fetched from the store on each pull.
module serial_boot_command_engine import bsce_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // rx_byte[7:0]
  input  logic        in_tuser,   // func[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // tx_byte[7:0]
  output logic        out_tlast,
  output logic        out_tuser,  // restart[0]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  bsce_cmd_t cmd;
  bsce_sts_t sts;

  bsce_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bsce_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

### sv/bsce_chk.sv
// Port-level checks for the boot command engine, bound to the top level.
// Depends on bsce_pkg.
module bsce_chk import bsce_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata,
  input logic        out_tlast,
  input logic        out_tuser,
  input logic        cfg_we,
  input logic        cfg_index,
  input logic [31:0] cfg_wdata
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("output word dropped while stalled");

  a_restart_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast && out_tdata == ACK_BYTE)
    else $error("restart not on a final ACK");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second word taken while one is in work");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !in_tready)
    else $error("activity right after reset");

endmodule

bind serial_boot_command_engine bsce_chk u_bsce_chk (.*);

### tb/serial_boot_command_engine_tb.sv
// Self-checking testbench for serial_boot_command_engine: drives host bytes and
// transmit pulls, predicts every reply byte and compares. Needs bsce_pkg.
`timescale 1ns / 100ps

module serial_boot_command_engine_tb;
  import bsce_pkg::*;

  typedef enum int {
    P_WAIT, P_CMD2, P_MAGIC, P_RM_ADDR, P_RM_LEN, P_RM_CK, P_GO_ADDR,
    P_WM_ADDR, P_WM_LEN, P_WM_DATA, P_WM_CK, P_ER_FIRST, P_ER_GLOBAL, P_ER_LIST
  } boot_phase_t;

  typedef struct packed {
    logic [7:0] tx;
    logic       last;
    logic       restart;
  } tx_word_t;

  localparam int IDLE_LIMIT = 300000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid, in_tready;
  logic [7:0]  in_tdata;   // rx_byte[7:0]
  logic        in_tuser;   // func[0]
  logic        out_tvalid, out_tready;
  logic [7:0]  out_tdata;  // tx_byte[7:0]
  logic        out_tlast;
  logic        out_tuser;  // restart[0]
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  serial_boot_command_engine dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  boot_phase_t ph;
  logic [7:0]  cmd_first, chk, cnt;
  logic [31:0] addr_reg, rd_addr, win_base, win_end;
  int unsigned idx, rd_left;
  logic [7:0]  pay_buf [BUF_BYTES];
  logic [7:0]  image [STORE_BYTES];
  bit          erased;
  tx_word_t    tx_expect [$];

  int errors, words_sent, words_checked, burst_left, long_hold_go;

  function automatic logic [7:0] image_rd(logic [31:0] a);
    logic [31:0] off;
    off = a - win_base;
    if (a < win_base || off >= STORE_BYTES) return 8'h00;
    return image[off];
  endfunction

  function automatic void image_wr(logic [31:0] a, logic [7:0] v);
    logic [31:0] off;
    off = a - win_base;
    if (a >= win_base && off < STORE_BYTES) image[off] = v;
  endfunction

  function automatic void erase_window();
    longint span, nbytes;
    if (erased) return;
    if (win_end > win_base) begin
      span = longint'(win_end - win_base);
      nbytes = ((span + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
      if (nbytes > STORE_BYTES) nbytes = STORE_BYTES;
      for (int i = 0; i < nbytes; i++) image[i] = ALL_ONES;
    end
    erased = 1'b1;
  endfunction

  function automatic void commit_halfwords();
    logic [31:0] a;
    int halves;
    a = addr_reg;
    halves = (cnt >> 1) + 1;
    for (int i = 0; i < halves; i++) begin
      if (a >= win_base && a < win_end) begin
        image_wr(a, pay_buf[(2 * i) % BUF_BYTES]);
        image_wr(a + 1, pay_buf[(2 * i + 1) % BUF_BYTES]);
        a += 2;
      end
    end
    addr_reg = a;
  endfunction

  // returns 1 once the check byte has been taken
  function automatic bit take_addr_byte(logic [7:0] b);
    if (idx < 4) addr_reg = {addr_reg[23:0], b};
    chk ^= b;
    idx++;
    return idx >= 5;
  endfunction

  function automatic void predict_word(logic func, logic [7:0] b);
    tx_word_t w [$];
    logic [7:0] diff;
    logic [7:0] rep [$];
    if (func) begin
      if (rd_left > 0) begin
        w.push_back('{image_rd(rd_addr), 1'b0, 1'b0});
        rd_addr++;
        rd_left--;
      end
    end else begin
      case (ph)
        P_WAIT: begin
          if (b == SYNC_BYTE) w.push_back('{ACK_BYTE, 1'b0, 1'b0});
          else begin
            cmd_first = b;
            ph = P_CMD2;
          end
        end
        P_CMD2: begin
          diff = b - cmd_first;
          ph = P_WAIT;
          case (diff)
            DIFF_GET: rep = '{8'h07, 8'h10, 8'h00, 8'h01, 8'h02, 8'h11, 8'h21, 8'h31, 8'h43};
            DIFF_VER: rep = '{8'h10, 8'h00, 8'h00};
            DIFF_ID:  rep = '{8'h01, 8'h04, 8'h10};
            default: ;
          endcase
          case (diff)
            DIFF_GET, DIFF_VER, DIFF_ID: begin
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
              foreach (rep[i]) w.push_back('{rep[i], 1'b0, 1'b0});
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
            end
            DIFF_RM, DIFF_GO, DIFF_WM: begin
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
              addr_reg = '0;
              chk = '0;
              idx = 0;
              ph = (diff == DIFF_RM) ? P_RM_ADDR : (diff == DIFF_GO) ? P_GO_ADDR : P_WM_ADDR;
            end
            DIFF_ER: begin
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
              ph = P_ER_FIRST;
            end
            DIFF_MAGIC: begin
              idx = 0;
              ph = P_MAGIC;
            end
            default: w.push_back('{NACK_BYTE, 1'b0, 1'b0});
          endcase
        end
        P_MAGIC: begin
          idx++;
          if (idx >= 12) ph = P_WAIT;
        end
        P_RM_ADDR, P_WM_ADDR: begin
          if (take_addr_byte(b)) begin
            if (chk != 0) begin
              w.push_back('{NACK_BYTE, 1'b0, 1'b0});
              ph = P_WAIT;
            end else begin
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
              ph = (ph == P_RM_ADDR) ? P_RM_LEN : P_WM_LEN;
            end
          end
        end
        P_RM_LEN: begin
          cnt = b;
          ph = P_RM_CK;
        end
        P_RM_CK: begin
          w.push_back('{ACK_BYTE, 1'b0, 1'b0});
          rd_addr = addr_reg;
          rd_left = cnt + 1;
          ph = P_WAIT;
        end
        P_GO_ADDR: begin
          if (take_addr_byte(b)) begin
            w.push_back('{ACK_BYTE, 1'b0, 1'b1});
            ph = P_WAIT;
          end
        end
        P_WM_LEN: begin
          cnt = b;
          chk = b;
          idx = 0;
          ph = P_WM_DATA;
        end
        P_WM_DATA: begin
          pay_buf[idx % BUF_BYTES] = b;
          chk ^= b;
          if (idx >= cnt) ph = P_WM_CK;
          idx++;
        end
        P_WM_CK: begin
          chk ^= b;
          if (chk != 0) w.push_back('{NACK_BYTE, 1'b0, 1'b0});
          else begin
            commit_halfwords();
            w.push_back('{ACK_BYTE, 1'b0, 1'b0});
          end
          ph = P_WAIT;
        end
        P_ER_FIRST: begin
          if (b == ALL_ONES) ph = P_ER_GLOBAL;
          else begin
            cnt = b;
            chk = b;
            idx = 0;
            ph = P_ER_LIST;
          end
        end
        P_ER_GLOBAL: begin
          erase_window();
          w.push_back('{ACK_BYTE, 1'b0, 1'b0});
          ph = P_WAIT;
        end
        P_ER_LIST: begin
          chk ^= b;
          idx++;
          if (idx >= cnt + 2) begin
            if (chk != 0) w.push_back('{NACK_BYTE, 1'b0, 1'b0});
            else begin
              erase_window();
              w.push_back('{ACK_BYTE, 1'b0, 1'b0});
            end
            ph = P_WAIT;
          end
        end
        default: ph = P_WAIT;
      endcase
    end
    if (w.size() > 0) w[w.size() - 1].last = 1'b1;
    foreach (w[i]) tx_expect.push_back(w[i]);
  endfunction

  // ---------------- drivers ----------------
  task automatic send_word(logic func, logic [7:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= func;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_word(func, b);
    words_sent++;
  endtask

  task automatic host(logic [7:0] b);
    send_word(1'b0, b);
  endtask

  task automatic pulls(int n);
    repeat (n) send_word(1'b1, $urandom_range(0, 255));
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (tx_expect.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic cfg_write(logic which, logic [31:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == REG_APP_BASE) win_base = v;
    else win_end = v;
  endtask

  task automatic command(logic [7:0] sel);
    logic [7:0] f;
    f = $urandom_range(0, 255);
    if (f == SYNC_BYTE) f = 8'h00;
    host(f);
    host(f + sel);
  endtask

  task automatic address(logic [31:0] a, bit good);
    logic [7:0] x;
    x = a[31:24] ^ a[23:16] ^ a[15:8] ^ a[7:0];
    host(a[31:24]);
    host(a[23:16]);
    host(a[15:8]);
    host(a[7:0]);
    host(good ? x : x ^ (8'h01 << $urandom_range(0, 7)));
  endtask

  task automatic read_mem(logic [31:0] a, logic [7:0] len, bit good, int extra);
    command(DIFF_RM);
    address(a, good);
    if (!good) return;
    host(len);
    host($urandom_range(0, 255));
    pulls(len + 1 + extra);
  endtask

  task automatic write_mem(logic [31:0] a, logic [7:0] len, bit good);
    logic [7:0] x, d;
    command(DIFF_WM);
    address(a, 1'b1);
    host(len);
    x = len;
    for (int i = 0; i <= len; i++) begin
      d = $urandom_range(0, 255);
      x ^= d;
      host(d);
    end
    host(good ? x : ~x);
  endtask

  task automatic erase(bit global, logic [7:0] n, bit good);
    logic [7:0] x, d;
    command(DIFF_ER);
    if (global) begin
      host(ALL_ONES);
      host($urandom_range(0, 255));
      return;
    end
    host(n);
    x = n;
    for (int i = 0; i < n + 1; i++) begin
      d = $urandom_range(0, 255);
      x ^= d;
      host(d);
    end
    host(good ? x : x ^ 8'h5A);
  endtask

  task automatic go_cmd(logic [31:0] a);
    command(DIFF_GO);
    address(a, $urandom_range(0, 1));
  endtask

  // feed random bytes until the engine is back waiting for a command
  task automatic resync();
    while (ph != P_WAIT) host($urandom_range(0, 255));
  endtask

  function automatic logic [31:0] pick_addr();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return win_end - $urandom_range(0, 8);
      2:       return win_base - $urandom_range(0, 8);
      default: return win_base + $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic random_command();
    logic [7:0] len;
    len = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 15);
    case ($urandom_range(0, 13))
      0:       host(SYNC_BYTE);
      1:       command(DIFF_GET);
      2:       command($urandom_range(0, 1) ? DIFF_VER : DIFF_ID);
      3, 4:    read_mem(pick_addr(), len, $urandom_range(0, 7) != 0, $urandom_range(0, 2));
      5, 6, 7: write_mem(pick_addr(), len, $urandom_range(0, 7) != 0);
      8:       go_cmd(pick_addr());
      9:       erase($urandom_range(0, 1), $urandom_range(0, 6), $urandom_range(0, 3) != 0);
      10: begin
        command(DIFF_MAGIC);
        repeat (12) host($urandom_range(0, 255));
      end
      11:      command($urandom_range(0, 255));
      12:      repeat ($urandom_range(1, 6)) host($urandom_range(0, 255));
      default: pulls($urandom_range(1, 4));
    endcase
    resync();
  endtask

  // ---------------- tests ----------------
  task automatic test_sync_and_info();
    host(SYNC_BYTE);
    command(DIFF_GET);
    command(DIFF_VER);
    command(DIFF_ID);
    pulls(2);  // nothing queued
    command(8'h42);
  endtask

  task automatic test_magic_skip();
    command(DIFF_MAGIC);
    host(SYNC_BYTE);
    repeat (10) host($urandom_range(0, 255));
    host(ALL_ONES);
    host(SYNC_BYTE);
  endtask

  task automatic test_write_read();
    write_mem(win_base, 8'd3, 1'b1);
    write_mem(win_base + 8, 8'd4, 1'b1);  // odd count: stale buffer byte
    write_mem(win_base + 16, 8'd1, 1'b0);
    write_mem(win_end - 2, 8'd7, 1'b1);   // runs off the window end
    read_mem(win_base, 8'd23, 1'b1, 2);
    read_mem(win_base, 8'd3, 1'b0, 0);
    read_mem(win_base - 2, 8'd3, 1'b1, 0);
    read_mem(win_base + 4, 8'd3, 1'b1, 0);
    command(DIFF_GET);  // host command after the read data; the pulls find nothing queued
    pulls(4);
    write_mem(win_base + 32, 8'd255, 1'b1);
    read_mem(win_base + 32, 8'd255, 1'b1, 0);
  endtask

  task automatic test_erase_once();
    erase(1'b0, 8'd2, 1'b0);
    erase(1'b1, 8'd0, 1'b1);
    read_mem(win_base, 8'd15, 1'b1, 0);
    write_mem(win_base, 8'd5, 1'b1);
    erase(1'b0, 8'd0, 1'b1);  // already erased: data stays
    read_mem(win_base, 8'd7, 1'b1, 0);
  endtask

  task automatic test_go();
    go_cmd(32'h0800_1000);
    go_cmd(32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    long_hold_go = 1;
    repeat (6) command(DIFF_GET);
    read_mem(win_base, 8'd20, 1'b1, 0);
    wait_drain();
  endtask

  task automatic test_windows();
    logic [31:0] bases [4] = '{32'h0000_0000, 32'hFFFF_FF00, 32'h2000_0000, 32'h0800_1000};
    logic [31:0] ends  [4] = '{32'hFFFF_FFFF, 32'h0000_0100, 32'h2000_0400, 32'h0800_1000};
    for (int s = 0; s < 4; s++) begin
      wait_drain();
      cfg_write(REG_APP_BASE, bases[s]);
      cfg_write(REG_APP_END, ends[s]);
      write_mem(win_base, 8'd9, 1'b1);
      write_mem(32'hFFFF_FFFE, 8'd3, 1'b1);
      write_mem(win_end - 4, 8'd7, 1'b1);
      read_mem(win_base - 2, 8'd13, 1'b1, 0);
      read_mem(32'hFFFF_FFFC, 8'd7, 1'b1, 0);
      repeat (10) random_command();
    end
    wait_drain();
    cfg_write(REG_APP_BASE, 32'h0800_1000);
    cfg_write(REG_APP_END, 32'h0801_0000);
  endtask

  task automatic test_random();
    int target;
    target = words_sent + 470;
    while (words_sent < target) random_command();
  endtask

  // ---------------- receiver stall pattern ----------------
  initial begin
    int cyc, hold_left;
    cyc = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (long_hold_go) begin
        long_hold_go = 0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        case ((cyc / 300) % 4)
          0:       out_tready <= 1'b1;
          1:       out_tready <= $urandom_range(0, 1);
          2:       out_tready <= (cyc % 5) != 0;
          default: out_tready <= (cyc % 7) < 2;
        endcase
      end
    end
  end

  // ---------------- result check ----------------
  always @(posedge clk) begin
    tx_word_t w;
    if (rst_n && out_tvalid && out_tready) begin
      if (tx_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected word: expected none, actual tx=%h last=%b restart=%b",
                 $time, out_tdata, out_tlast, out_tuser);
      end else begin
        w = tx_expect.pop_front();
        words_checked++;
        if (out_tdata !== w.tx) begin
          errors++;
          $display("%0t: tx_byte mismatch: expected %h actual %h", $time, w.tx, out_tdata);
        end
        if (out_tlast !== w.last) begin
          errors++;
          $display("%0t: last mismatch: expected %b actual %b", $time, w.last, out_tlast);
        end
        if (out_tuser !== w.restart) begin
          errors++;
          $display("%0t: restart mismatch: expected %b actual %b",
                   $time, w.restart, out_tuser);
        end
      end
    end
  end

  // ---------------- watchdog ----------------
  always @(posedge clk) begin
    int idle_cycles;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- main sequence ----------------
  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= 1'b0;
    cfg_wdata <= '0;
    errors = 0;
    words_sent = 0;
    words_checked = 0;
    burst_left = 0;
    long_hold_go = 0;
    ph = P_WAIT;
    cmd_first = '0;
    addr_reg = '0;
    chk = '0;
    cnt = '0;
    idx = 0;
    rd_addr = '0;
    rd_left = 0;
    erased = 1'b0;
    foreach (pay_buf[i]) pay_buf[i] = 8'h00;
    foreach (image[i]) image[i] = ALL_ONES;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    cfg_write(REG_APP_BASE, 32'h0800_1000);
    cfg_write(REG_APP_END, 32'h0801_0000);

    test_sync_and_info();
    test_magic_skip();
    test_write_read();
    test_erase_once();
    test_go();
    test_backpressure();
    test_random();
    test_windows();

    wait_drain();
    $display("Covered sync, get/version/id, read, write, go, erase and magic commands,");
    $display("bad checks and four address windows: %0d words in, %0d reply words checked.",
             words_sent, words_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
